FILE: rtl/murc_pkg.sv
// Shared types and constants for the modem URC line parser
package murc_pkg;

    localparam int LineLimitDefault = 160;

    typedef enum logic [1:0] {
        CMD_BYTE        = 2'd0,
        CMD_CLR_PROMPT  = 2'd1,
        CMD_CLR_CONN    = 2'd2,
        CMD_NOP         = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        PH_WS1  = 4'd0,
        PH_SGN1 = 4'd1,
        PH_DIG1 = 4'd2,
        PH_WS2  = 4'd3,
        PH_SGN2 = 4'd4,
        PH_DIG2 = 4'd5,
        PH_ONE  = 4'd6,
        PH_TWO  = 4'd7,
        PH_FAIL = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        KIND_MATCH   = 3'd0,
        KIND_CIPOPEN = 3'd1,
        KIND_CIPEVT  = 3'd2,
        KIND_NETOPEN = 3'd3,
        KIND_IPD     = 3'd4,
        KIND_NONE    = 3'd5
    } kind_t;

    typedef struct packed {
        logic link_up;
        logic network_open;
        logic prompt_seen;
        logic body_valid;
        logic [7:0] body_byte;
        logic body_last;
    } result_t;

    function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [3:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0: case (i)
                4'd0: c = "+"; 4'd1: c = "C"; 4'd2: c = "I"; 4'd3: c = "P";
                4'd4: c = "O"; 4'd5: c = "P"; 4'd6: c = "E"; 4'd7: c = "N";
                4'd8: c = ":"; default: c = 8'h00;
            endcase
            2'd1: case (i)
                4'd0: c = "+"; 4'd1: c = "C"; 4'd2: c = "I"; 4'd3: c = "P";
                4'd4: c = "E"; 4'd5: c = "V"; 4'd6: c = "E"; 4'd7: c = "N";
                4'd8: c = "T"; 4'd9: c = ":"; default: c = 8'h00;
            endcase
            2'd2: case (i)
                4'd0: c = "+"; 4'd1: c = "N"; 4'd2: c = "E"; 4'd3: c = "T";
                4'd4: c = "O"; 4'd5: c = "P"; 4'd6: c = "E"; 4'd7: c = "N";
                4'd8: c = ":"; default: c = 8'h00;
            endcase
            default: case (i)
                4'd0: c = "+"; 4'd1: c = "I"; 4'd2: c = "P"; 4'd3: c = "D";
                4'd4: c = ":"; default: c = 8'h00;
            endcase
        endcase
        return c;
    endfunction

    function automatic logic [3:0] prefix_len(input logic [1:0] k);
        logic [3:0] n;
        case (k)
            2'd0: n = 4'd9;
            2'd1: n = 4'd10;
            2'd2: n = 4'd9;
            default: n = 4'd5;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] closed_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0: c = "C"; 3'd1: c = "L"; 3'd2: c = "O";
            3'd3: c = "S"; 3'd4: c = "E"; 3'd5: c = "D";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/murc_num.sv
// Decimal field parser step: phase advance and saturating accumulate
module murc_num
    import murc_pkg::*;
(
    input  logic [3:0]  phase,
    input  logic [7:0]  ch,
    input  logic        two,
    input  logic [16:0] num1,
    input  logic [16:0] num2,
    output logic [3:0]  phase_next,
    output logic [16:0] num1_next,
    output logic [16:0] num2_next
);

    logic        dig;
    logic        sgn;
    logic        blank;
    logic [15:0] acc_in;
    logic [20:0] prod;
    logic [15:0] acc_mag;

    assign dig   = (ch >= "0") && (ch <= "9");
    assign sgn   = (ch == "+") || (ch == "-");
    assign blank = (ch == " ") || (ch == 8'h09) || (ch == 8'h0B) || (ch == 8'h0C)
                   || (ch == 8'h0D) || (ch == 8'h0A);

    assign acc_in = (phase == PH_WS1 || phase == PH_SGN1 || phase == PH_DIG1)
                    ? num1[15:0] : num2[15:0];
    assign prod   = {5'd0, acc_in} * 21'd10 + {17'd0, ch[3:0]};
    assign acc_mag = (prod > 21'd65535) ? 16'hFFFF : prod[15:0];

    always_comb
    begin
        phase_next = phase;
        num1_next  = num1;
        num2_next  = num2;
        case (phase)
            PH_WS1:
            begin
                if (blank) phase_next = PH_WS1;
                else if (sgn)
                begin
                    if (ch == "-") num1_next[16] = 1'b1;
                    phase_next = PH_SGN1;
                end
                else if (dig)
                begin
                    num1_next = {num1[16], acc_mag};
                    phase_next = PH_DIG1;
                end
                else phase_next = PH_FAIL;
            end
            PH_SGN1:
            begin
                if (dig)
                begin
                    num1_next = {num1[16], acc_mag};
                    phase_next = PH_DIG1;
                end
                else phase_next = PH_FAIL;
            end
            PH_DIG1:
            begin
                if (dig) num1_next = {num1[16], acc_mag};
                else if (two && ch == ",") phase_next = PH_WS2;
                else phase_next = PH_ONE;
            end
            PH_WS2:
            begin
                if (blank) phase_next = PH_WS2;
                else if (sgn)
                begin
                    if (ch == "-") num2_next[16] = 1'b1;
                    phase_next = PH_SGN2;
                end
                else if (dig)
                begin
                    num2_next = {num2[16], acc_mag};
                    phase_next = PH_DIG2;
                end
                else phase_next = PH_ONE;
            end
            PH_SGN2:
            begin
                if (dig)
                begin
                    num2_next = {num2[16], acc_mag};
                    phase_next = PH_DIG2;
                end
                else phase_next = PH_ONE;
            end
            PH_DIG2:
            begin
                if (dig) num2_next = {num2[16], acc_mag};
                else phase_next = PH_TWO;
            end
            default: phase_next = phase;
        endcase
    end

endmodule

FILE: rtl/modem_urc_line_parser_core.sv
// Top level of the modem URC line parser
// An accepted word's result word is registered in the output register in the next cycle.
// Throughput: one word per cycle while in_stall is low; the whole step is one pass of logic over the parser state.
// The output register holds a result while stalled; a new word enters when it empties
// or drains in the same cycle.
// Reset: rst_n asynchronously clears all flags, counters and the parse state.
module modem_urc_line_parser_core
    import murc_pkg::*;
#(
    parameter int LINE_LIMIT = LineLimitDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       link_up,
    output logic       network_open,
    output logic       prompt_seen,
    output logic       body_valid,
    output logic [7:0] body_byte,
    output logic       body_last
);

    logic        conn_reg, conn_next;
    logic        net_reg, net_next;
    logic        prompt_reg, prompt_next;
    logic [15:0] body_rem_reg, body_rem_next;
    logic [7:0]  pos_reg, pos_next;
    logic        cut_reg, cut_next;
    logic [2:0]  kind_reg, kind_next;
    logic [3:0]  fld_reg, fld_next;
    logic [16:0] num1_reg, num1_next;
    logic [16:0] num2_reg, num2_next;
    logic [2:0]  cls_reg, cls_next;
    logic        out_valid_reg;
    result_t     res_reg, res_next;

    logic        take;
    logic [3:0]  ph_step;
    logic [16:0] n1_step, n2_step;
    logic [3:0]  elim;
    logic [2:0]  found;
    logic [3:0]  idx4;
    logic        first_ok, second_ok;

    assign in_stall = out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;
    assign idx4     = pos_reg[3:0];

    murc_num u_num (
        .phase      (fld_reg),
        .ch         (rx_byte),
        .two        (kind_reg != KIND_NETOPEN),
        .num1       (num1_reg),
        .num2       (num2_reg),
        .phase_next (ph_step),
        .num1_next  (n1_step),
        .num2_next  (n2_step)
    );

    always_comb
    begin
        elim  = fld_reg;
        found = 3'd0;
        for (int k = 0; k < 4; k++)
        begin
            if (!fld_reg[k])
            begin
                if (pos_reg < {4'd0, prefix_len(2'(k))}
                    && rx_byte == prefix_char(2'(k), idx4))
                begin
                    if (pos_reg == {4'd0, prefix_len(2'(k)) - 4'd1})
                        found = 3'(k + 1);
                end
                else elim[k] = 1'b1;
            end
        end
    end

    assign first_ok  = (fld_reg >= PH_DIG1) && (fld_reg <= PH_TWO);
    assign second_ok = (fld_reg == PH_DIG2) || (fld_reg == PH_TWO);

    always_comb
    begin
        conn_next     = conn_reg;
        net_next      = net_reg;
        prompt_next   = prompt_reg;
        body_rem_next = body_rem_reg;
        pos_next      = pos_reg;
        cut_next      = cut_reg;
        kind_next     = kind_reg;
        fld_next      = fld_reg;
        num1_next     = num1_reg;
        num2_next     = num2_reg;
        cls_next      = cls_reg;
        res_next      = '0;
        case (cmd_t'(command))
            CMD_CLR_PROMPT: prompt_next = 1'b0;
            CMD_CLR_CONN:   conn_next = 1'b0;
            CMD_BYTE:
            begin
                if (rx_byte == ">") prompt_next = 1'b1;
                else if (body_rem_reg != 16'd0)
                begin
                    res_next.body_valid = 1'b1;
                    res_next.body_byte  = rx_byte;
                    res_next.body_last  = (body_rem_reg == 16'd1);
                    body_rem_next = body_rem_reg - 16'd1;
                end
                else if (rx_byte == 8'h0A)
                begin
                    if (pos_reg != 8'd0)
                    begin
                        case (kind_reg)
                            KIND_CIPOPEN: conn_next = first_ok && second_ok
                                && num1_reg[15:0] == 16'd0 && num2_reg[15:0] == 16'd0;
                            KIND_CIPEVT: if (cls_reg == 3'd6) conn_next = 1'b0;
                            KIND_NETOPEN: if (first_ok && num1_reg[15:0] == 16'd0)
                                net_next = 1'b1;
                            KIND_IPD: if (second_ok && num1_reg[15:0] == 16'd0
                                && !num2_reg[16] && num2_reg[15:0] != 16'd0)
                                body_rem_next = num2_reg[15:0];
                            default: ;
                        endcase
                        pos_next  = 8'd0;
                        cut_next  = 1'b0;
                        kind_next = KIND_MATCH;
                        fld_next  = 4'd0;
                        num1_next = '0;
                        num2_next = '0;
                        cls_next  = 3'd0;
                    end
                end
                else if (rx_byte != 8'h0D && pos_reg < 8'(LINE_LIMIT - 1))
                begin
                    pos_next = pos_reg + 8'd1;
                    if (!cut_reg)
                    begin
                        if (rx_byte == 8'h00) cut_next = 1'b1;
                        else
                        begin
                            if (cls_reg < 3'd6)
                            begin
                                if (rx_byte == closed_char(cls_reg)) cls_next = cls_reg + 3'd1;
                                else cls_next = (rx_byte == "C") ? 3'd1 : 3'd0;
                            end
                            case (kind_reg)
                                KIND_MATCH:
                                begin
                                    if (found != 3'd0)
                                    begin
                                        kind_next = found;
                                        fld_next  = PH_WS1;
                                    end
                                    else if (elim == 4'hF)
                                    begin
                                        kind_next = KIND_NONE;
                                        fld_next  = 4'd0;
                                    end
                                    else fld_next = elim;
                                end
                                KIND_CIPOPEN, KIND_NETOPEN, KIND_IPD:
                                begin
                                    fld_next  = ph_step;
                                    num1_next = n1_step;
                                    num2_next = n2_step;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            default: ;
        endcase
        res_next.link_up      = conn_next;
        res_next.network_open = net_next;
        res_next.prompt_seen  = prompt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_reg      <= 1'b0;
            net_reg       <= 1'b0;
            prompt_reg    <= 1'b0;
            body_rem_reg  <= '0;
            pos_reg       <= '0;
            cut_reg       <= 1'b0;
            kind_reg      <= KIND_MATCH;
            fld_reg       <= '0;
            num1_reg      <= '0;
            num2_reg      <= '0;
            cls_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                conn_reg     <= conn_next;
                net_reg      <= net_next;
                prompt_reg   <= prompt_next;
                body_rem_reg <= body_rem_next;
                pos_reg      <= pos_next;
                cut_reg      <= cut_next;
                kind_reg     <= kind_next;
                fld_reg      <= fld_next;
                num1_reg     <= num1_next;
                num2_reg     <= num2_next;
                cls_reg      <= cls_next;
            end
            if (take) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign link_up      = res_reg.link_up;
    assign network_open = res_reg.network_open;
    assign prompt_seen  = res_reg.prompt_seen;
    assign body_valid   = res_reg.body_valid;
    assign body_byte    = res_reg.body_byte;
    assign body_last    = res_reg.body_last;

    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < 8'(LINE_LIMIT))
        else $error("line position past limit");
    a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
        cls_reg <= 3'd6)
        else $error("closed match progress out of range");
    a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
        take && body_rem_reg != 16'd0 && rx_byte != ">" && command == CMD_BYTE
        |=> body_rem_reg == $past(body_rem_reg) - 16'd1)
        else $error("body count did not drop");
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && body_last |-> body_valid)
        else $error("body_last without body_valid");

endmodule

FILE: test/murc_checker.sv
// Checker for the modem URC line parser: predicts each result word and compares it
module murc_checker
    import murc_pkg::*;
#(
    parameter int LINE_LIMIT = LineLimitDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       link_up,
    input  logic       network_open,
    input  logic       prompt_seen,
    input  logic       body_valid,
    input  logic [7:0] body_byte,
    input  logic       body_last,
    output int         fail_count,
    output int         pending_count
);

    localparam logic [16:0] SIGN_BIT = 17'h10000;

    result_t     flags_due[$];
    logic        conn_q;
    logic        net_q;
    logic        prompt_q;
    logic [15:0] body_left;
    logic [7:0]  line_pos;
    logic        line_cut;
    kind_t       line_kind;
    logic [3:0]  line_field;
    logic [16:0] num_a;
    logic [16:0] num_b;
    logic [2:0]  closed_pos;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c
            || c == 8'h0d || c == 8'h0a;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [16:0] push_digit(input logic [16:0] n, input logic [7:0] c);
        logic [31:0] mag;
        mag = n[15:0] * 10 + (c - "0");
        if (mag > 32'hffff)
            mag = 32'hffff;
        return {n[16], mag[15:0]};
    endfunction

    task automatic number_step(input logic [7:0] c, input logic pair);
        logic dig;
        logic sgn;
        dig = is_digit(c);
        sgn = c == "+" || c == "-";
        case (line_field)
            PH_WS1:
                if (is_blank(c)) line_field = PH_WS1;
                else if (sgn)
                begin
                    if (c == "-") num_a |= SIGN_BIT;
                    line_field = PH_SGN1;
                end
                else if (dig)
                begin
                    num_a = push_digit(num_a, c);
                    line_field = PH_DIG1;
                end
                else line_field = PH_FAIL;
            PH_SGN1:
                if (dig)
                begin
                    num_a = push_digit(num_a, c);
                    line_field = PH_DIG1;
                end
                else line_field = PH_FAIL;
            PH_DIG1:
                if (dig) num_a = push_digit(num_a, c);
                else if (pair && c == ",") line_field = PH_WS2;
                else line_field = PH_ONE;
            PH_WS2:
                if (is_blank(c)) line_field = PH_WS2;
                else if (sgn)
                begin
                    if (c == "-") num_b |= SIGN_BIT;
                    line_field = PH_SGN2;
                end
                else if (dig)
                begin
                    num_b = push_digit(num_b, c);
                    line_field = PH_DIG2;
                end
                else line_field = PH_ONE;
            PH_SGN2:
                if (dig)
                begin
                    num_b = push_digit(num_b, c);
                    line_field = PH_DIG2;
                end
                else line_field = PH_ONE;
            PH_DIG2:
                if (dig) num_b = push_digit(num_b, c);
                else line_field = PH_TWO;
            default: ;
        endcase
    endtask

    task automatic store_char(input logic [7:0] idx, input logic [7:0] c);
        logic [3:0] gone;
        logic [2:0] hit;
        if (line_cut) return;
        if (c == 8'h00)
        begin
            line_cut = 1'b1;
            return;
        end
        if (closed_pos < 3'd6)
        begin
            if (c == closed_char(closed_pos)) closed_pos++;
            else closed_pos = (c == "C") ? 3'd1 : 3'd0;
        end
        if (line_kind == KIND_MATCH)
        begin
            gone = line_field;
            hit = 3'd0;
            for (int k = 0; k < 4; k++)
            begin
                if (!gone[k])
                begin
                    if (idx < prefix_len(2'(k)) && c == prefix_char(2'(k), idx[3:0]))
                    begin
                        if (idx == prefix_len(2'(k)) - 1) hit = 3'(k + 1);
                    end
                    else gone[k] = 1'b1;
                end
            end
            if (hit != 0)
            begin
                line_kind = kind_t'(hit);
                line_field = PH_WS1;
            end
            else if (gone == 4'hf)
            begin
                line_kind = KIND_NONE;
                line_field = 4'd0;
            end
            else line_field = gone;
        end
        else if (line_kind == KIND_CIPOPEN || line_kind == KIND_IPD)
            number_step(c, 1'b1);
        else if (line_kind == KIND_NETOPEN)
            number_step(c, 1'b0);
    endtask

    task automatic close_line();
        logic ok_a;
        logic ok_b;
        ok_a = line_field >= PH_DIG1 && line_field <= PH_TWO;
        ok_b = line_field == PH_DIG2 || line_field == PH_TWO;
        case (line_kind)
            KIND_CIPOPEN: conn_q = ok_a && ok_b && num_a[15:0] == 0 && num_b[15:0] == 0;
            KIND_CIPEVT: if (closed_pos >= 3'd6) conn_q = 1'b0;
            KIND_NETOPEN: if (ok_a && num_a[15:0] == 0) net_q = 1'b1;
            KIND_IPD:
                if (ok_b && num_a[15:0] == 0 && !num_b[16] && num_b[15:0] > 0)
                    body_left = num_b[15:0];
            default: ;
        endcase
        line_pos = 0;
        line_cut = 1'b0;
        line_kind = KIND_MATCH;
        line_field = 4'd0;
        num_a = 0;
        num_b = 0;
        closed_pos = 0;
    endtask

    task automatic predict_word(input logic [1:0] cmd, input logic [7:0] b);
        result_t r;
        r = '0;
        if (cmd == CMD_CLR_PROMPT) prompt_q = 1'b0;
        else if (cmd == CMD_CLR_CONN) conn_q = 1'b0;
        else if (cmd == CMD_BYTE)
        begin
            if (b == ">") prompt_q = 1'b1;
            else if (body_left > 0)
            begin
                r.body_valid = 1'b1;
                r.body_byte = b;
                r.body_last = body_left == 1;
                body_left--;
            end
            else if (b == 8'h0a)
            begin
                if (line_pos > 0) close_line();
            end
            else if (b != 8'h0d && line_pos < LINE_LIMIT - 1)
            begin
                store_char(line_pos, b);
                line_pos++;
            end
        end
        r.link_up = conn_q;
        r.network_open = net_q;
        r.prompt_seen = prompt_q;
        flags_due.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    assign pending_count = flags_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t w;
        if (!rst_n)
        begin
            flags_due.delete();
            fail_count = 0;
            conn_q = 0;
            net_q = 0;
            prompt_q = 0;
            body_left = 0;
            line_pos = 0;
            line_cut = 0;
            line_kind = KIND_MATCH;
            line_field = 0;
            num_a = 0;
            num_b = 0;
            closed_pos = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (flags_due.size() == 0)
                begin
                    $display("%0t: unexpected result word", $time);
                    fail_count++;
                end
                else
                begin
                    w = flags_due.pop_front();
                    check_field("link_up", w.link_up, link_up);
                    check_field("network_open", w.network_open, network_open);
                    check_field("prompt_seen", w.prompt_seen, prompt_seen);
                    check_field("body_valid", w.body_valid, body_valid);
                    check_field("body_byte", w.body_byte, body_byte);
                    check_field("body_last", w.body_last, body_last);
                end
            end
            if (in_valid && !in_stall)
                predict_word(command, rx_byte);
        end
    end

endmodule

FILE: test/testbench.sv
// Stimulus and verdict for the modem URC line parser testbench
module testbench;
    import murc_pkg::*;

    localparam int WATCHDOG = 2000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       link_up;
    logic       network_open;
    logic       prompt_seen;
    logic       body_valid;
    logic [7:0] body_byte;
    logic       body_last;
    int         fail_count;
    int         pending_count;
    int         send_idle;
    int         recv_stall;
    int         quiet_cycles = 0;

    modem_urc_line_parser_core u_dut (.*);

    murc_checker u_check (.*);

    always #4 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_word(input cmd_t cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(CMD_BYTE, s[i]);
    endtask

    function automatic string pick_number();
        case ($urandom_range(7))
            0: return "0";
            1: return "-0";
            2: return "+0";
            3: return "99999";
            4: return $sformatf("%0d", $urandom_range(65535));
            5: return "";
            6: return $sformatf("%0d", $urandom_range(9));
            default: return " 00";
        endcase
    endfunction

    function automatic string pick_line();
        string s;
        case ($urandom_range(7))
            0: s = {"+CIPOPEN: ", pick_number(), ",", pick_number()};
            1: s = {"+CIPEVENT: 0,", ($urandom_range(1) ? "CLOSED" : "CLOSXED")};
            2: s = {"+NETOPEN: ", pick_number()};
            3: s = {"+IPD: 0,", $sformatf("%0d", $urandom_range(1, 12))};
            4: s = {"+IPD:", pick_number(), ", ", pick_number()};
            5: s = {"+CIP", pick_number(), "OK"};
            6: s = {"+NET", "OPEN:0", "\r"};
            default: s = "OK";
        endcase
        return {s, "\r\n"};
    endfunction

    task automatic random_word();
        int r;
        r = $urandom_range(99);
        if (r < 3) send_word(CMD_CLR_PROMPT, 8'($urandom));
        else if (r < 6) send_word(CMD_CLR_CONN, 8'($urandom));
        else if (r < 8) send_word(CMD_NOP, 8'($urandom));
        else if (r < 10) send_word(CMD_BYTE, ">");
        else send_word(CMD_BYTE, 8'($urandom));
    endtask

    task automatic random_phase(input int words);
        int sent;
        string s;
        sent = 0;
        while (sent < words)
        begin
            if ($urandom_range(9) < 7)
            begin
                s = pick_line();
                send_text(s);
                sent += s.len();
            end
            else
            begin
                random_word();
                sent++;
            end
        end
    endtask

    initial
    begin
        string long_line;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_BYTE;
        rx_byte = 8'h00;
        send_idle = 0;
        recv_stall = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_text("\n\r\n");
        send_text("+NETOPEN: 0\r\n");
        send_text("+CIPOPEN: -0, +0\r\n");
        send_word(CMD_BYTE, ">");
        send_word(CMD_CLR_PROMPT, 8'hff);
        send_word(CMD_NOP, 8'h00);
        send_text("+IPD:0,3\n");
        send_text("a>\n");
        send_word(CMD_BYTE, 8'hff);
        send_text("+CIPEVENT: CLCLOSED\n");
        send_word(CMD_CLR_CONN, 8'h55);
        send_text("+CIPOPEN:0,0\n");
        in_valid <= 1'b0;
        wait (pending_count == 0);
        @(negedge clk);
        send_word(CMD_BYTE, 8'h00);
        send_text("+IPD: 99999,-1\n");
        long_line = "+CIPOPEN:0,0";
        for (int i = 0; i < 170; i++) long_line = {long_line, "x"};
        send_text({long_line, "\n"});

        recv_stall = 0; send_idle = 0;
        random_phase(450);
        send_idle = 75;
        random_phase(350);
        send_idle = 0; recv_stall = 75;
        random_phase(350);
        send_idle = 8; recv_stall = 8;
        random_phase(400);

        in_valid <= 1'b0;
        wait (pending_count == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
